FILE: design/pfba_pkg.sv
// shared constants and types for the page frame bitmap allocator
package pfba_pkg;

  // default sizing of the bitmap
  localparam int unsigned DefMaxPages  = 65536;
  localparam int unsigned DefPageShift = 12;

  // configuration register file
  localparam int unsigned   CfgAddrW       = 3;
  localparam int unsigned   CfgDataW       = 32;
  localparam logic          RegTotalPages  = 1'b0;  // register index, paddr bit 2
  localparam logic [16:0]   TotalPagesRst  = 17'h10000;

  // stream word widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    OpAlloc    = 2'd0,
    OpFree     = 2'd1,
    OpMarkUsed = 2'd2,
    OpMarkFree = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusNoFree     = 2'd1,
    StatusOutOfRange = 2'd2
  } status_e;

endpackage

FILE: design/page_frame_bitmap_allocator.sv
// page frame bitmap allocator: first-fit allocate, free and range marking
//
// channels: commands enter on s_axis (tuser the opcode, tdata the free address, the
//   range start page and the range page count); every command gives one result word on
//   m_axis (allocated address, status, previous use bit of a freed page); the user must
//   write total_pages via the apb port only while the block is idle; it is not enforced
// timing: the bitmap sits in one 32-bit wide memory with a registered read, one
//   bitmap word per cycle with reads and write-backs overlapped
//   allocate scans bitmap words from word 0 up to the first with a clear bit (at
//     most ceil(limit / 32) words, 2048 with the defaults); range ops touch the
//     words of the clipped range, and free touches one word
//   an out-of-range free, an empty range or an allocate with a zero limit touch
//     no bitmap word
//   one command is worked on at a time
// reset: a clearing pass writes every bitmap word, (MaxPages + 31) / 32 of them,
//   2048 with the defaults, to all ones (every page used), with s_axis_tready
//   low; total_pages resets to 65536
// stall: a result waits in the output register while m_axis_tready is low; the
//   next command is taken and worked on, and its result waits for the register
module page_frame_bitmap_allocator #(
  parameter int unsigned MaxPages  = pfba_pkg::DefMaxPages,
  parameter int unsigned PageShift = pfba_pkg::DefPageShift
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfba_pkg::CfgAddrW-1:0]   paddr,
  input  logic [pfba_pkg::CfgDataW-1:0]   pwdata,
  output logic [pfba_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  // command words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // address [31:0], start_page [47:32], page_count [64:48], zero pad [71:65]
  input  logic [pfba_pkg::InDataW-1:0]    s_axis_tdata,
  // op [1:0]
  input  logic [pfba_pkg::InUserW-1:0]    s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // alloc_address [31:0], status [33:32], was_used [34], zero pad [39:35]
  output logic [pfba_pkg::OutDataW-1:0]   m_axis_tdata
);
  import pfba_pkg::*;

  localparam int unsigned Words = (MaxPages + 31) / 32;
  localparam int unsigned IdxW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CntW  = $clog2(Words + 1);
  localparam int unsigned LimW  = ($clog2(MaxPages + 1) > 18) ? $clog2(MaxPages + 1) : 18;
  localparam logic [LimW-1:0] MaxLim  = LimW'(MaxPages);
  localparam logic [CntW-1:0] LastClr = CntW'(Words - 1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StPrep,
    StAlloc,
    StWalk,
    StDone
  } state_e;

  // control state
  state_e            state_q, state_d;
  logic [16:0]       total_pages_q, total_pages_d;
  logic [CntW-1:0]   ri_q, ri_d;          // next word to read, also clear counter
  logic [IdxW-1:0]   ck_q, ck_d;          // word whose read data is arriving
  logic              dv_q, dv_d;          // read data valid
  logic              out_valid_q, out_valid_d;

  // working payload
  op_e               op_q;
  logic [31:0]       addr_q;
  logic [15:0]       start_q;
  logic [16:0]       count_q;
  logic [IdxW-1:0]   first_q, first_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [4:0]        lo_q, lo_d;
  logic [4:0]        hi_q, hi_d;
  logic              set_q, set_d;
  status_e           status_q, status_d;
  logic              was_used_q, was_used_d;
  logic [31:0]       alloc_q, alloc_d;
  logic [OutDataW-1:0] out_data_q;

  // bitmap memory
  logic [31:0]       bitmap_mem [Words];
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  logic [31:0]       mem_wd;
  logic [IdxW-1:0]   mem_ra;
  logic [31:0]       mem_rd_q;

  // decode helpers
  logic [LimW-1:0]   limit;
  logic [LimW-1:0]   limit_m1;
  logic [31:0]       free_page;
  logic [LimW-1:0]   range_end;
  logic              range_clip;
  logic [LimW-1:0]   range_endc;
  logic [LimW-1:0]   range_last;
  status_e           range_status;
  logic              issue;
  logic [4:0]        low_clear;
  logic [31:0]       found_page;
  logic [4:0]        lo_sel;
  logic [4:0]        hi_sel;
  logic [31:0]       mask;
  logic              slot_free;
  logic              cfg_wr;

  // apb side
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegTotalPages) ? {15'd0, total_pages_q} : '0;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign slot_free     = !out_valid_q || m_axis_tready;

  // active page limit
  assign limit    = (LimW'(total_pages_q) < MaxLim) ? LimW'(total_pages_q) : MaxLim;
  assign limit_m1 = limit - LimW'(1);

  // free: page from byte address
  assign free_page = 32'(addr_q >> PageShift);

  // range: clip at the limit
  assign range_end    = LimW'(start_q) + LimW'(count_q);
  assign range_clip   = range_end > limit;
  assign range_endc   = range_clip ? limit : range_end;
  assign range_last   = range_endc - LimW'(1);
  assign range_status = (range_clip && (count_q != '0)) ? StatusOutOfRange : StatusOk;

  // read issue while words are left
  assign issue = (ri_q <= CntW'(last_q));

  // lowest clear bit of the arriving word
  always_comb begin
    low_clear = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!mem_rd_q[i]) low_clear = 5'(i);
    end
  end

  assign found_page = (32'(ck_q) << 5) | 32'(low_clear);

  // bit mask of the range inside the arriving word
  assign lo_sel = (ck_q == first_q) ? lo_q : 5'd0;
  assign hi_sel = (ck_q == last_q) ? hi_q : 5'd31;
  assign mask   = (32'hFFFF_FFFF << lo_sel) & (32'hFFFF_FFFF >> (5'd31 - hi_sel));

  always_comb begin
    state_d       = state_q;
    total_pages_d = total_pages_q;
    ri_d          = ri_q;
    ck_d          = ck_q;
    dv_d          = 1'b0;
    out_valid_d   = out_valid_q;
    first_d       = first_q;
    last_d        = last_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    set_d         = set_q;
    status_d      = status_q;
    was_used_d    = was_used_q;
    alloc_d       = alloc_q;
    mem_we        = 1'b0;
    mem_wa        = ck_q;
    mem_wd        = mem_rd_q;
    mem_ra        = ri_q[IdxW-1:0];

    if (cfg_wr && (paddr[2] == RegTotalPages)) total_pages_d = pwdata[16:0];
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      StClear: begin
        // write all ones through the whole bitmap
        mem_we = 1'b1;
        mem_wa = ri_q[IdxW-1:0];
        mem_wd = '1;
        ri_d   = ri_q + CntW'(1);
        if (ri_q == LastClr) state_d = StIdle;
      end

      StIdle: begin
        if (s_axis_tvalid) state_d = StPrep;
      end

      StPrep: begin
        status_d   = StatusOk;
        was_used_d = 1'b0;
        alloc_d    = '0;
        case (op_q) inside
          OpAlloc: begin
            if (limit == '0) begin
              status_d = StatusNoFree;
              state_d  = StDone;
            end else begin
              ri_d    = '0;
              last_d  = IdxW'(limit_m1 >> 5);
              state_d = StAlloc;
            end
          end
          OpFree: begin
            if (free_page >= 32'(limit)) begin
              status_d = StatusOutOfRange;
              state_d  = StDone;
            end else begin
              first_d = IdxW'(free_page >> 5);
              last_d  = IdxW'(free_page >> 5);
              lo_d    = free_page[4:0];
              hi_d    = free_page[4:0];
              set_d   = 1'b0;
              ri_d    = CntW'(free_page >> 5);
              state_d = StWalk;
            end
          end
          OpMarkUsed, OpMarkFree: begin
            status_d = range_status;
            if (LimW'(start_q) >= range_endc) begin
              state_d = StDone;
            end else begin
              first_d = IdxW'(start_q >> 5);
              last_d  = IdxW'(range_last >> 5);
              lo_d    = start_q[4:0];
              hi_d    = range_last[4:0];
              set_d   = (op_q == OpMarkUsed);
              ri_d    = CntW'(start_q >> 5);
              state_d = StWalk;
            end
          end
          default: state_d = StDone;
        endcase
      end

      StAlloc: begin
        if (issue) begin
          ri_d = ri_q + CntW'(1);
          ck_d = ri_q[IdxW-1:0];
          dv_d = 1'b1;
        end
        if (dv_q) begin
          if (mem_rd_q != '1) begin
            // first word with a free page; stop the scan here
            if (found_page < 32'(limit)) begin
              mem_we  = 1'b1;
              mem_wd  = mem_rd_q | (32'd1 << low_clear);
              alloc_d = 32'(found_page << PageShift);
            end else begin
              status_d = StatusNoFree;
            end
            state_d = StDone;
          end else if (ck_q == last_q) begin
            status_d = StatusNoFree;
            state_d  = StDone;
          end
        end
      end

      StWalk: begin
        if (issue) begin
          ri_d = ri_q + CntW'(1);
          ck_d = ri_q[IdxW-1:0];
          dv_d = 1'b1;
        end
        if (dv_q) begin
          mem_we = 1'b1;
          mem_wd = set_q ? (mem_rd_q | mask) : (mem_rd_q & ~mask);
          if (op_q == OpFree) was_used_d = |(mem_rd_q & mask);
          if (ck_q == last_q) state_d = StDone;
        end
      end

      StDone: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StClear;
      total_pages_q <= TotalPagesRst;
      ri_q          <= '0;
      ck_q          <= '0;
      dv_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      total_pages_q <= total_pages_d;
      ri_q          <= ri_d;
      ck_q          <= ck_d;
      dv_q          <= dv_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      op_q    <= op_e'(s_axis_tuser[1:0]);
      addr_q  <= s_axis_tdata[31:0];
      start_q <= s_axis_tdata[47:32];
      count_q <= s_axis_tdata[64:48];
    end
    first_q    <= first_d;
    last_q     <= last_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    set_q      <= set_d;
    status_q   <= status_d;
    was_used_q <= was_used_d;
    alloc_q    <= alloc_d;
    if (state_q == StDone && slot_free) begin
      out_data_q <= {5'd0, was_used_q, status_q, alloc_q};
    end
  end

  // bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_mem[mem_wa] <= mem_wd;
    mem_rd_q <= bitmap_mem[mem_ra];
  end

endmodule
